// ----- hw/rtl/ordered_token_filter_macros.svh -----
// Assertion macros used by the ordered token filter checker.
`ifndef ORDERED_TOKEN_FILTER_MACROS_SVH
`define ORDERED_TOKEN_FILTER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define OTF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define OTF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/otf_pkg.sv -----
// Shared types, widths and register codes of the ordered token filter.
package otf_pkg;

    localparam int DEF_MAX_NEEDLES  = 4;
    localparam int DEF_NEEDLE_BYTES = 8;
    localparam int DEF_INDEX_BITS   = 16;

    localparam int REG_NEEDLES  = 4;
    localparam int CHAR_W       = 8;
    localparam int COUNT_W      = 3;
    localparam int LEN_FIELD_W  = 4;
    localparam int LENGTHS_W    = REG_NEEDLES * LEN_FIELD_W;
    localparam int NEEDLE_W     = 64;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int OUT_IDX_W    = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEEDLE_COUNT   = 3'd0,
        REG_NEEDLE_LENGTHS = 3'd1,
        REG_NEEDLE_ZERO    = 3'd2,
        REG_NEEDLE_ONE     = 3'd3,
        REG_NEEDLE_TWO     = 3'd4,
        REG_NEEDLE_THREE   = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] string_index;
        logic                 is_visible;
        logic [OUT_IDX_W-1:0] visible_total;
    } t_result;

endpackage

// ----- hw/rtl/ordered_token_filter.sv -----
// Ordered multi-needle substring filter over a stream of string bytes.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_char_byte, i_has_char, i_is_last
//  out     | output    | o_out_valid / i_out_stall  | o_string_index, o_is_visible,
//          |           |                            | o_visible_total
//  cfg     | input     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// One input transaction per cycle while o_in_stall is low: the window compare and
// counter update of a byte finish in the cycle it is accepted, and the result of a
// closing item is registered in the output register, or in the one-entry skid stage
// when that register is held, so o_in_stall rises only when both are full.
// Synchronous active-low reset; there is no clearing pass.
module ordered_token_filter #(
    parameter int MAX_NEEDLES  = otf_pkg::DEF_MAX_NEEDLES,
    parameter int NEEDLE_BYTES = otf_pkg::DEF_NEEDLE_BYTES,
    parameter int INDEX_BITS   = otf_pkg::DEF_INDEX_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [otf_pkg::CHAR_W-1:0]      i_char_byte,
    input  logic                            i_has_char,
    input  logic                            i_is_last,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [otf_pkg::OUT_IDX_W-1:0]   o_string_index,
    output logic                            o_is_visible,
    output logic [otf_pkg::OUT_IDX_W-1:0]   o_visible_total,
    input  logic                            i_cfg_we,
    input  logic [otf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [otf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int ACT_MAX = (MAX_NEEDLES < otf_pkg::REG_NEEDLES) ?
                             MAX_NEEDLES : otf_pkg::REG_NEEDLES;
    localparam int POS_W   = $clog2(ACT_MAX + 1);
    localparam int WIN_W   = otf_pkg::CHAR_W * NEEDLE_BYTES;
    localparam int BSM_W   = $clog2(NEEDLE_BYTES + 1);
    localparam int CNT_W   = (INDEX_BITS < otf_pkg::OUT_IDX_W) ? INDEX_BITS : otf_pkg::OUT_IDX_W;
    localparam int CW      = otf_pkg::CHAR_W;

    // configuration
    logic [otf_pkg::COUNT_W-1:0]   r_needle_count;
    logic [otf_pkg::LENGTHS_W-1:0] r_needle_lengths;
    logic [otf_pkg::NEEDLE_W-1:0]  r_needle_bytes [otf_pkg::REG_NEEDLES];

    // per-string state
    logic [WIN_W-1:0] r_win, n_win;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [BSM_W-1:0] r_bsm, n_bsm;
    logic [CNT_W-1:0] r_str_cnt, n_str_cnt;
    logic [CNT_W-1:0] r_vis_cnt, n_vis_cnt;

    // result buffering
    logic             r_out_valid, n_out_valid;
    logic             r_skid_valid, n_skid_valid;
    otf_pkg::t_result r_out, r_skid, res;
    logic             out_load, skid_load, out_from_skid, out_take;

    logic                            in_accept;
    logic                            emit;
    logic [POS_W-1:0]                n_active;
    logic [otf_pkg::NEEDLE_W-1:0]    sel_pat;
    logic [otf_pkg::LEN_FIELD_W-1:0] sel_len_raw;
    logic [BSM_W-1:0]                len_c;
    logic [BSM_W-1:0]                bsm_inc;
    logic [WIN_W-1:0]                win_shift;
    logic                            len_match;
    logic                            cmp_ok;
    logic                            hit;
    logic [POS_W-1:0]                pos_step;
    logic                            vis;
    logic [CNT_W-1:0]                vis_cnt_step;

    assign in_accept = i_in_valid && !r_skid_valid;
    assign emit      = in_accept && i_is_last;
    assign out_take  = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_count   <= '0;
            r_needle_lengths <= '0;
            for (int k = 0; k < otf_pkg::REG_NEEDLES; k++) begin
                r_needle_bytes[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (otf_pkg::t_cfg_reg'(i_cfg_index))
                otf_pkg::REG_NEEDLE_COUNT: begin
                    r_needle_count <= i_cfg_data[otf_pkg::COUNT_W-1:0];
                end
                otf_pkg::REG_NEEDLE_LENGTHS: begin
                    r_needle_lengths <= i_cfg_data[otf_pkg::LENGTHS_W-1:0];
                end
                otf_pkg::REG_NEEDLE_ZERO:  r_needle_bytes[0] <= i_cfg_data;
                otf_pkg::REG_NEEDLE_ONE:   r_needle_bytes[1] <= i_cfg_data;
                otf_pkg::REG_NEEDLE_TWO:   r_needle_bytes[2] <= i_cfg_data;
                otf_pkg::REG_NEEDLE_THREE: r_needle_bytes[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // clamp count, pick the current needle and its clamped length
    always_comb begin
        if (r_needle_count > otf_pkg::COUNT_W'(ACT_MAX)) begin
            n_active = POS_W'(ACT_MAX);
        end else begin
            n_active = POS_W'(r_needle_count);
        end

        sel_pat     = '0;
        sel_len_raw = '0;
        for (int k = 0; k < ACT_MAX; k++) begin
            if (int'(r_pos) == k) begin
                sel_pat     = r_needle_bytes[k];
                sel_len_raw = r_needle_lengths[k*otf_pkg::LEN_FIELD_W +: otf_pkg::LEN_FIELD_W];
            end
        end

        if (sel_len_raw == '0) begin
            len_c = BSM_W'(1);
        end else if (sel_len_raw > otf_pkg::LEN_FIELD_W'(NEEDLE_BYTES)) begin
            len_c = BSM_W'(NEEDLE_BYTES);
        end else begin
            len_c = BSM_W'(sel_len_raw);
        end
    end

    // shift the byte in and compare the window against the needle for each length
    always_comb begin
        win_shift = WIN_W'({r_win, i_char_byte});
        if (r_bsm < BSM_W'(NEEDLE_BYTES)) begin
            bsm_inc = r_bsm + BSM_W'(1);
        end else begin
            bsm_inc = r_bsm;
        end

        len_match = 1'b0;
        for (int l = 1; l <= NEEDLE_BYTES; l++) begin
            cmp_ok = 1'b1;
            for (int j = 0; j < l; j++) begin
                if (sel_pat[CW*j +: CW] != win_shift[CW*(l-1-j) +: CW]) begin
                    cmp_ok = 1'b0;
                end
            end
            if (len_c == BSM_W'(l)) begin
                len_match = cmp_ok;
            end
        end

        hit      = i_has_char && (r_pos < n_active) && (bsm_inc >= len_c) && len_match;
        pos_step = hit ? r_pos + POS_W'(1) : r_pos;
        vis      = pos_step >= n_active;

        if (vis && (r_vis_cnt != '1)) begin
            vis_cnt_step = r_vis_cnt + CNT_W'(1);
        end else begin
            vis_cnt_step = r_vis_cnt;
        end

        res.string_index  = otf_pkg::OUT_IDX_W'(r_str_cnt);
        res.is_visible    = vis;
        res.visible_total = otf_pkg::OUT_IDX_W'(vis_cnt_step);
    end

    // state update on an accepted transaction
    always_comb begin
        n_win     = r_win;
        n_pos     = r_pos;
        n_bsm     = r_bsm;
        n_str_cnt = r_str_cnt;
        n_vis_cnt = r_vis_cnt;
        if (in_accept) begin
            if (i_has_char) begin
                n_win = win_shift;
                n_pos = pos_step;
                n_bsm = hit ? '0 : bsm_inc;
            end
            if (i_is_last) begin
                n_win     = '0;
                n_pos     = '0;
                n_bsm     = '0;
                n_vis_cnt = vis_cnt_step;
                if (r_str_cnt != '1) begin
                    n_str_cnt = r_str_cnt + CNT_W'(1);
                end
            end
        end
    end

    // output register with one skid entry behind it
    always_comb begin
        n_out_valid   = r_out_valid;
        n_skid_valid  = r_skid_valid;
        out_load      = 1'b0;
        skid_load     = 1'b0;
        out_from_skid = 1'b0;
        if (r_skid_valid) begin
            if (out_take) begin
                out_from_skid = 1'b1;
                n_skid_valid  = 1'b0;
            end
        end else begin
            if (out_take) begin
                n_out_valid = 1'b0;
            end
            if (emit) begin
                if (!r_out_valid || out_take) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                end else begin
                    skid_load    = 1'b1;
                    n_skid_valid = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win        <= '0;
            r_pos        <= '0;
            r_bsm        <= '0;
            r_str_cnt    <= '0;
            r_vis_cnt    <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_win        <= n_win;
            r_pos        <= n_pos;
            r_bsm        <= n_bsm;
            r_str_cnt    <= n_str_cnt;
            r_vis_cnt    <= n_vis_cnt;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= res;
        end else if (out_from_skid) begin
            r_out <= r_skid;
        end
        if (skid_load) begin
            r_skid <= res;
        end
    end

    assign o_in_stall      = r_skid_valid;
    assign o_out_valid     = r_out_valid;
    assign o_string_index  = r_out.string_index;
    assign o_is_visible    = r_out.is_visible;
    assign o_visible_total = r_out.visible_total;

endmodule

// ----- hw/rtl/otf_checker.sv -----
// Port-level checker for the ordered token filter, bound to the top level.
`include "ordered_token_filter_macros.svh"

module otf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [otf_pkg::OUT_IDX_W-1:0]   o_string_index,
    input logic                            o_is_visible,
    input logic [otf_pkg::OUT_IDX_W-1:0]   o_visible_total
);

    // a stalled result transaction holds its payload
    `OTF_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_string_index) && $stable(o_is_visible) && $stable(o_visible_total), "stalled result changed")

    // input backpressure only while a result waits in front of the skid entry
    `OTF_ASSERT_SAME(a_stall_has_result, o_in_stall, o_out_valid, "input stalled with no pending result")

    // visible strings never outnumber strings seen
    `OTF_ASSERT_SAME(a_total_bound, o_out_valid, 17'(o_visible_total) <= 17'(o_string_index) + 17'd1, "visible total above string count")

    // a visible string is counted
    `OTF_ASSERT_SAME(a_visible_counted, o_out_valid && o_is_visible, o_visible_total != '0, "visible string with zero total")

endmodule

bind ordered_token_filter otf_checker u_otf_checker (.*);
